@@ rtl/lpd_pkg.sv @@
// Shared types, constants and status codes of the length-prefix deframer.
package lpd_pkg;

    // Width of the payload length counter.
    localparam int LENGTH_BITS = 21;

    localparam int MAX_LEN_WIDTH = 21;
    localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = MAX_LEN_WIDTH'(1024 * 1024);

    // Largest length the counter can hold, kept wide enough for a 32-bit header.
    localparam logic [32:0] LEN_MASK = (33'd1 << LENGTH_BITS) - 33'd1;

    localparam logic [2:0] HEADER_LAST_IDX = 3'd3;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [2:0] ST_PAYLOAD     = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_OVERSIZE    = 3'd2;
    localparam logic [2:0] ST_CLEAN_END   = 3'd3;
    localparam logic [2:0] ST_PARTIAL_END = 3'd4;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic       frame_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]             header_bytes_seen;
        logic [23:0]            length_shift;
        logic [LENGTH_BITS-1:0] payload_remaining;
        logic                   error_latched;
    } state_t;

endpackage

@@ rtl/length_prefix_deframer_top.sv @@
// Top level of the length-prefix deframer: input register, framing state and result register.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+-------------------------------
//   byte      | in        | byte_valid / byte_ready   | byte_item (operation, data_byte)
//   result    | out       | result_valid/result_ready | result_item (byte, status, last)
//   cfg       | in        | cfg_write                 | cfg_data (max_payload_length)
//
// One item is accepted per cycle unless results stall; any result passes both registers.
// The framing state updates as an item moves from the input register to the result register.
// A stall on the result side holds both registers, and the input register then fills up.
// Reset clears the framing state and sets the maximum length to 1 MiB.
module length_prefix_deframer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_ready,
    input  lpd_pkg::in_item_t                   byte_item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lpd_pkg::out_item_t                  result_item,
    input  logic                                cfg_write,
    input  logic [lpd_pkg::MAX_LEN_WIDTH-1:0]   cfg_data
);

    logic                              stage_valid_reg;
    lpd_pkg::in_item_t                 stage_item_reg;
    lpd_pkg::state_t                   state_reg;
    lpd_pkg::state_t                   state_next;
    logic [lpd_pkg::MAX_LEN_WIDTH-1:0] max_len_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    lpd_pkg::out_item_t                out_item_reg;
    logic                              core_ok;
    lpd_pkg::out_item_t                core_result;
    logic                              advance;

    lpd_core u_core (
        .state      (state_reg),
        .item       (stage_item_reg),
        .max_len    (max_len_reg),
        .state_next (state_next),
        .result_ok  (core_ok),
        .result     (core_result)
    );

    assign advance    = stage_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !stage_valid_reg || advance;

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = core_ok;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            state_reg       <= '0;
            max_len_reg     <= lpd_pkg::MAX_LEN_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                stage_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_write)
            begin
                max_len_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            stage_item_reg <= byte_item;
        end
        if (advance && core_ok)
        begin
            out_item_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // An oversize header leaves no header or payload count behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_latched |-> (state_reg.header_bytes_seen == 3'd0 &&
                                     state_reg.payload_remaining == '0))
        else $error("error latched with framing counters still set");

    // A payload count is only loaded once the header is complete.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.payload_remaining != '0) |-> (state_reg.header_bytes_seen == 3'd0))
        else $error("payload pending while header bytes are counted");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.header_bytes_seen <= lpd_pkg::HEADER_LAST_IDX)
        else $error("header byte count out of range");

    // A waiting result is never overwritten by the stage behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("stalled result changed");

endmodule

@@ rtl/lpd_core.sv @@
// Per-byte framing logic: next state and the optional result for one item.
module lpd_core (
    input  lpd_pkg::state_t                     state,
    input  lpd_pkg::in_item_t                   item,
    input  logic [lpd_pkg::MAX_LEN_WIDTH-1:0]   max_len,
    output lpd_pkg::state_t                     state_next,
    output logic                                result_ok,
    output lpd_pkg::out_item_t                  result
);

    logic [32:0] limit;
    logic [32:0] declared;
    logic        pending;

    always_comb
    begin
        limit = (33'(max_len) > lpd_pkg::LEN_MASK) ? lpd_pkg::LEN_MASK : 33'(max_len);
        declared = {1'b0, state.length_shift, item.data_byte};
        pending = (state.header_bytes_seen != 3'd0) || (state.payload_remaining != '0)
                  || state.error_latched;
    end

    always_comb
    begin
        state_next = state;
        result_ok  = 1'b0;
        result     = '0;
        priority if (item.operation == lpd_pkg::OP_END)
        begin
            result_ok     = 1'b1;
            result.status = pending ? lpd_pkg::ST_PARTIAL_END : lpd_pkg::ST_CLEAN_END;
            state_next    = '0;
        end
        else if (state.error_latched)
        begin
            // Bytes after an oversize header are dropped until end of stream.
            state_next = state;
        end
        else if (state.payload_remaining != '0)
        begin
            state_next.payload_remaining = state.payload_remaining
                                           - lpd_pkg::LENGTH_BITS'(1);
            result_ok           = 1'b1;
            result.payload_byte = item.data_byte;
            result.status       = lpd_pkg::ST_PAYLOAD;
            result.frame_last   = (state.payload_remaining == lpd_pkg::LENGTH_BITS'(1));
        end
        else if (state.header_bytes_seen < lpd_pkg::HEADER_LAST_IDX)
        begin
            state_next.length_shift      = {state.length_shift[15:0], item.data_byte};
            state_next.header_bytes_seen = state.header_bytes_seen + 3'd1;
        end
        else
        begin
            state_next.header_bytes_seen = 3'd0;
            state_next.length_shift      = '0;
            if (declared > limit)
            begin
                state_next.error_latched = 1'b1;
                result_ok     = 1'b1;
                result.status = lpd_pkg::ST_OVERSIZE;
            end
            else if (declared == 33'd0)
            begin
                result_ok         = 1'b1;
                result.status     = lpd_pkg::ST_EMPTY;
                result.frame_last = 1'b1;
            end
            else
            begin
                state_next.payload_remaining = declared[lpd_pkg::LENGTH_BITS-1:0];
            end
        end
    end

endmodule

@@ bench/tb_length_prefix_deframer_top.sv @@
// Self-checking testbench of the length-prefix deframer, with its own frame predictor.
module tb_length_prefix_deframer_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 14;
    localparam int RANDOM_PHASE_ITEMS = 64;
    localparam int BODY_CAP = 16;
    localparam logic [lpd_pkg::MAX_LEN_WIDTH-1:0] MAX_LEN_TOP = '1;

    logic                              clk;
    logic                              rst_n;
    logic                              byte_valid;
    logic                              byte_ready;
    lpd_pkg::in_item_t                 byte_item;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    lpd_pkg::out_item_t                result_item;
    logic                              cfg_write;
    logic [lpd_pkg::MAX_LEN_WIDTH-1:0] cfg_data;

    // Predictor state, mirroring the framing state of the block.
    logic [2:0]                        hdr_seen;
    logic [23:0]                       len_shift;
    logic [lpd_pkg::LENGTH_BITS-1:0]   remaining;
    logic                              err_latched;
    logic [lpd_pkg::MAX_LEN_WIDTH-1:0] max_len;

    lpd_pkg::out_item_t pending_results[$];
    lpd_pkg::out_item_t want;
    int        fail_count = 0;
    int        sent_count;
    int        cycle_count = 0;
    bit        no_idle;

    length_prefix_deframer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: byte=%02h status=%0d last=%0d", $time,
                         result_item.payload_byte, result_item.status, result_item.frame_last);
                fail_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (result_item.payload_byte !== want.payload_byte ||
                    result_item.status !== want.status ||
                    result_item.frame_last !== want.frame_last)
                begin
                    $display("%0t: expected b=%02h s=%0d l=%0d, actual b=%02h s=%0d l=%0d",
                             $time, want.payload_byte, want.status, want.frame_last,
                             result_item.payload_byte, result_item.status,
                             result_item.frame_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_result(input lpd_pkg::out_item_t r);
        pending_results = {pending_results, r};
    endtask

    // Works out what one accepted item produces and advances the predicted state.
    task automatic model_deframe(input lpd_pkg::in_item_t item);
        lpd_pkg::out_item_t r;
        logic [31:0]        declared;
        r = '0;
        if (item.operation == lpd_pkg::OP_END)
        begin
            r.status = (hdr_seen != 0 || remaining != 0 || err_latched) ?
                       lpd_pkg::ST_PARTIAL_END : lpd_pkg::ST_CLEAN_END;
            queue_result(r);
            hdr_seen = '0;
            len_shift = '0;
            remaining = '0;
            err_latched = 1'b0;
        end
        else if (err_latched)
        begin
            // Bytes are dropped until the stream ends.
        end
        else if (remaining != 0)
        begin
            remaining = remaining - lpd_pkg::LENGTH_BITS'(1);
            r.payload_byte = item.data_byte;
            r.status = lpd_pkg::ST_PAYLOAD;
            r.frame_last = (remaining == 0);
            queue_result(r);
        end
        else if (hdr_seen < lpd_pkg::HEADER_LAST_IDX)
        begin
            len_shift = {len_shift[15:0], item.data_byte};
            hdr_seen = hdr_seen + 3'd1;
        end
        else
        begin
            declared = {len_shift, item.data_byte};
            hdr_seen = '0;
            len_shift = '0;
            // The register is no wider than the counter, so it is the limit itself.
            if (declared > 32'(max_len))
            begin
                err_latched = 1'b1;
                r.status = lpd_pkg::ST_OVERSIZE;
                queue_result(r);
            end
            else if (declared == 0)
            begin
                r.status = lpd_pkg::ST_EMPTY;
                r.frame_last = 1'b1;
                queue_result(r);
            end
            else
            begin
                remaining = declared[lpd_pkg::LENGTH_BITS-1:0];
            end
        end
    endtask

    task automatic send_item(input lpd_pkg::in_item_t item);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        model_deframe(item);
        sent_count++;
    endtask

    task automatic send_data(input logic [7:0] value);
        send_item(lpd_pkg::in_item_t'{operation: lpd_pkg::OP_DATA, data_byte: value});
    endtask

    task automatic send_end();
        send_item(lpd_pkg::in_item_t'{operation: lpd_pkg::OP_END, data_byte: 8'($urandom())});
    endtask

    task automatic send_header(input logic [31:0] len);
        send_data(len[31:24]);
        send_data(len[23:16]);
        send_data(len[15:8]);
        send_data(len[7:0]);
    endtask

    // Sends a header and up to body_cap payload bytes; a frame cut short is closed by an end item.
    task automatic send_frame(input logic [31:0] len, input int body_cap);
        int n;
        send_header(len);
        n = (len > 32'(body_cap)) ? body_cap : int'(len);
        repeat (n) send_data(8'($urandom()));
        if (32'(n) < len)
            send_end();
    endtask

    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [lpd_pkg::MAX_LEN_WIDTH-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        max_len = value;
    endtask

    task automatic test_reset_state();
        send_end();
        send_header(32'd2);
        send_data(8'h00);
        send_data(8'hFF);
        send_header(32'(lpd_pkg::MAX_LEN_RESET));
        send_data(8'hA5);
        send_end();
        send_header(32'(lpd_pkg::MAX_LEN_RESET) + 32'd1);
        send_data(8'h5A);
        send_end();
        send_data(8'h12);
        send_end();
    endtask

    task automatic test_length_limits();
        write_max_len('0);
        send_header(32'd0);
        send_header(32'd1);
        send_end();
        write_max_len(MAX_LEN_TOP);
        send_header(32'(MAX_LEN_TOP));
        send_data(8'h3C);
        send_end();
        send_header(32'hFFFF_FFFF);
        send_end();
    endtask

    task automatic send_random_frame();
        logic [31:0] len;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = $urandom_range(0, 12);
        else if (pick < 70)
            len = 32'd0;
        else if (pick < 85)
            len = 32'(max_len) + 32'($urandom_range(0, 1));
        else
            len = $urandom();
        send_frame(len, ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : BODY_CAP);
        // Mostly recover from an oversize length, so that later frames are framed again.
        if (err_latched && $urandom_range(0, 4) != 0)
            send_end();
    endtask

    task automatic test_random_stream();
        logic [lpd_pkg::MAX_LEN_WIDTH-1:0] limits[6];
        int                                target;
        limits[0] = '0;
        limits[1] = lpd_pkg::MAX_LEN_WIDTH'(1);
        limits[2] = lpd_pkg::MAX_LEN_WIDTH'(12);
        limits[3] = lpd_pkg::MAX_LEN_WIDTH'($urandom_range(0, int'(MAX_LEN_TOP)));
        limits[4] = MAX_LEN_TOP;
        limits[5] = lpd_pkg::MAX_LEN_RESET;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_max_len(limits[phase]);
            no_idle = (phase == 2);
            target = sent_count + RANDOM_PHASE_ITEMS;
            while (sent_count < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(lpd_pkg::in_item_t'{
                        operation: ($urandom_range(0, 3) == 0) ?
                                   lpd_pkg::OP_END : lpd_pkg::OP_DATA,
                        data_byte: 8'($urandom())});
                else
                    send_random_frame();
                if (phase == 3 && sent_count >= target - RANDOM_PHASE_ITEMS / 2 &&
                    sent_count < target - RANDOM_PHASE_ITEMS / 2 + 4)
                    wait_idle();
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        hdr_seen = '0;
        len_shift = '0;
        remaining = '0;
        err_latched = 1'b0;
        max_len = lpd_pkg::MAX_LEN_RESET;
        sent_count = 0;
        no_idle = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_length_limits();
        test_random_stream();

        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lpd_pkg.sv
rtl/lpd_core.sv
rtl/length_prefix_deframer_top.sv
bench/tb_length_prefix_deframer_top.sv
